// ===== sv/assert_macros.svh =====
// assertion macros used by the top level rtl file of the calendar counter
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ccc_pkg.sv =====
// types, constants and the month length table for the calendar counter
// no dependencies
package ccc_pkg;

    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_SET_ALL  = 2'd1;
    localparam logic [1:0] KIND_SET_DATE = 2'd2;

    localparam logic [6:0]  MAX_SECOND = 7'd59;
    localparam logic [6:0]  MAX_MINUTE = 7'd59;
    localparam logic [5:0]  MAX_HOUR   = 6'd23;
    localparam logic [4:0]  MAX_MONTH  = 5'd12;
    localparam logic [13:0] MAX_YEAR   = 14'd9999;

    // february always 28 days
    localparam logic [4:0] MONTH_DAYS [0:11] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  new_second;
        logic [5:0]  new_minute;
        logic [4:0]  new_hour;
        logic [4:0]  new_day;
        logic [3:0]  new_month;
        logic [13:0] new_year;
    } req_t;

    typedef struct packed {
        logic [5:0]  cur_second;
        logic [5:0]  cur_minute;
        logic [4:0]  cur_hour;
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [13:0] cur_year;
        logic        time_valid;
        logic        minute_event;
        logic        day_event;
    } rsp_t;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } cal_state_t;

    typedef struct packed {
        cal_state_t state;
        logic       minute_event;
        logic       day_event;
    } step_out_t;

    // month outside one to twelve counts as 31 days
    function automatic logic [4:0] days_in(input logic [3:0] month);
        logic [4:0] len;
        len = 5'd31;
        if (month >= 4'd1 && month <= 4'd12)
        begin
            len = MONTH_DAYS[month - 4'd1];
        end
        return len;
    endfunction

endpackage

// ===== sv/ccc_step.sv =====
// next-state logic for one beat: tick carry cascade or set load
// depends on ccc_pkg
module ccc_step
    import ccc_pkg::*;
(
    input  cal_state_t cur,
    input  req_t       req,
    input  logic       fast_mode,
    output step_out_t  step
);

    logic [6:0]  sec_inc;
    logic [6:0]  min_inc;
    logic [5:0]  hour_inc;
    logic [5:0]  day_inc;
    logic [4:0]  month_inc;
    logic        sec_wrap;
    logic        min_wrap;
    logic        hour_wrap;
    logic        day_wrap;
    logic        month_wrap;
    logic        adv_min;
    logic        adv_hour;
    logic        adv_day;
    logic        adv_month;
    logic        adv_year;
    cal_state_t  ticked;

    always_comb
    begin
        sec_inc   = {1'b0, cur.second} + 7'd1;
        min_inc   = {1'b0, cur.minute} + 7'd1;
        hour_inc  = {1'b0, cur.hour} + 6'd1;
        day_inc   = {1'b0, cur.day} + 6'd1;
        month_inc = {1'b0, cur.month} + 5'd1;

        sec_wrap   = sec_inc > MAX_SECOND;
        min_wrap   = min_inc > MAX_MINUTE;
        hour_wrap  = hour_inc > MAX_HOUR;
        day_wrap   = day_inc > {1'b0, days_in(cur.month)};
        month_wrap = month_inc > MAX_MONTH;

        adv_min   = fast_mode || sec_wrap;
        adv_hour  = adv_min && min_wrap;
        adv_day   = adv_hour && hour_wrap;
        adv_month = adv_day && day_wrap;
        adv_year  = adv_month && month_wrap;

        ticked = cur;
        if (!fast_mode)
        begin
            ticked.second = sec_wrap ? 6'd0 : sec_inc[5:0];
        end
        if (adv_min)
        begin
            ticked.minute = min_wrap ? 6'd0 : min_inc[5:0];
        end
        if (adv_hour)
        begin
            ticked.hour = hour_wrap ? 5'd0 : hour_inc[4:0];
        end
        if (adv_day)
        begin
            ticked.day = day_wrap ? 5'd1 : day_inc[4:0];
        end
        if (adv_month)
        begin
            ticked.month = month_wrap ? 4'd1 : month_inc[3:0];
        end
        if (adv_year)
        begin
            ticked.year = (cur.year >= MAX_YEAR) ? 14'd0 : cur.year + 14'd1;
        end

        step.state        = cur;
        step.minute_event = 1'b0;
        step.day_event    = 1'b0;
        case (req.kind)
            KIND_TICK:
            begin
                step.state        = ticked;
                step.minute_event = adv_min;
                step.day_event    = adv_day;
            end
            KIND_SET_ALL:
            begin
                step.state.second = req.new_second;
                step.state.minute = req.new_minute;
                step.state.hour   = req.new_hour;
                step.state.day    = req.new_day;
                step.state.month  = req.new_month;
                step.state.year   = req.new_year;
            end
            KIND_SET_DATE:
            begin
                step.state.day   = req.new_day;
                step.state.month = req.new_month;
                step.state.year  = req.new_year;
            end
            default:
            begin
                step.state = cur;
            end
        endcase
    end

endmodule

// ===== sv/ccc_check.sv =====
// calendar range check on a counter state, year not checked
// depends on ccc_pkg
module ccc_check
    import ccc_pkg::*;
(
    input  cal_state_t state,
    output logic       time_valid
);

    logic month_ok;
    logic day_ok;
    logic clock_ok;

    always_comb
    begin
        month_ok   = ({1'b0, state.month} >= 5'd1) && ({1'b0, state.month} <= MAX_MONTH);
        day_ok     = (state.day >= 5'd1) && (state.day <= days_in(state.month));
        clock_ok   = ({1'b0, state.second} <= MAX_SECOND)
                  && ({1'b0, state.minute} <= MAX_MINUTE)
                  && ({1'b0, state.hour} <= MAX_HOUR);
        time_valid = month_ok && day_ok && clock_ok;
    end

endmodule

// ===== sv/calendar_clock_counter.sv =====
// top level of the calendar counter: beat registers, counter state, output register
// depends on ccc_pkg, ccc_step, ccc_check and assert_macros.svh
`include "assert_macros.svh"

// Calendar clock counter without leap years. A request beat either ticks the
// clock (one second, or one minute when fast_mode is set) or loads the full
// time or the date only, with no range check; kind 3 changes nothing. Every
// request beat gives exactly one response beat with the counters after the
// request, a range flag and minute/day rollover pulses. Reset leaves
// 00:00:00 on day 1, month 1, year 0 with fast_mode clear. Throughput is one
// beat per clock while the response side is not stalled. The request beat
// waits in the request register, then one pass through the second-to-year
// carry cascade lands it in the counter state and response register once
// that register is free or drained. The request side keeps taking beats
// while a response waits, as long as the request register can hand its
// beat on; with a stalled response one more beat fits into an empty request
// register. fast_mode is to be written through cfg_we/cfg_wdata only while
// no beat is in flight; the block itself does not enforce this.
module calendar_clock_counter
    import ccc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,

    input  logic cfg_we,
    input  logic cfg_wdata,

    input  logic req_valid,
    output logic req_ready,
    input  req_t req,

    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // request stage
    logic       req_valid_reg;
    req_t       req_reg;
    // calendar counters and mode
    cal_state_t state_reg;
    logic       fast_mode_reg;
    // response stage
    logic       rsp_valid_reg;
    rsp_t       rsp_reg;

    logic       advance;
    step_out_t  step;
    logic       time_valid;
    rsp_t       rsp_next;

    // terms for the checks at the end
    logic       day_at_midnight;
    logic       rsp_in_step;
    logic       set_advance;
    logic       rsp_no_events;

    // request register moves on when the response register is free or drained
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;

    ccc_step u_step (
        .cur       (state_reg),
        .req       (req_reg),
        .fast_mode (fast_mode_reg),
        .step      (step)
    );

    // range flag is taken on the state after this beat
    ccc_check u_check (
        .state      (step.state),
        .time_valid (time_valid)
    );

    always_comb
    begin
        rsp_next.cur_second   = step.state.second;
        rsp_next.cur_minute   = step.state.minute;
        rsp_next.cur_hour     = step.state.hour;
        rsp_next.cur_day      = step.state.day;
        rsp_next.cur_month    = step.state.month;
        rsp_next.cur_year     = step.state.year;
        rsp_next.time_valid   = time_valid;
        rsp_next.minute_event = step.minute_event;
        rsp_next.day_event    = step.day_event;
    end

    // control and counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg    <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            fast_mode_reg    <= 1'b0;
            state_reg.second <= 6'd0;
            state_reg.minute <= 6'd0;
            state_reg.hour   <= 5'd0;
            state_reg.day    <= 5'd1;
            state_reg.month  <= 4'd1;
            state_reg.year   <= 14'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                fast_mode_reg <= cfg_wdata;
            end
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            if (advance)
            begin
                state_reg     <= step.state;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign day_at_midnight = !rsp_reg.day_event
                          || (rsp_reg.minute_event && rsp_reg.cur_hour == 5'd0
                              && rsp_reg.cur_minute == 6'd0);
    assign rsp_in_step     = (rsp_reg.cur_second == state_reg.second)
                          && (rsp_reg.cur_day == state_reg.day)
                          && (rsp_reg.cur_year == state_reg.year);
    assign set_advance     = advance && (req_reg.kind != KIND_TICK);
    assign rsp_no_events   = !rsp_reg.minute_event && !rsp_reg.day_event;

    // a day rollover always comes with a minute advance at midnight
    `ASSERT_ALWAYS(a_day_implies_midnight, !rsp_valid_reg || day_at_midnight, "day event off midnight")
    // the response on display always matches the counter state in second, day and year
    `ASSERT_ALWAYS(a_rsp_tracks_state, !rsp_valid_reg || rsp_in_step, "response out of step")
    // a held request reaches the response register once it is empty
    `ASSERT_NEXT(a_req_moves_on, req_valid_reg && !rsp_valid_reg, rsp_valid_reg, "beat not handed on")
    // set beats never raise rollover pulses
    `ASSERT_NEXT(a_set_no_events, set_advance, rsp_no_events, "rollover pulse on a set beat")

endmodule
